### src/rgb_pixel_format_converter_macros.svh
// Assertion macros of the pixel format converter RTL.
// Needs nothing else; included by the top level, the only module that carries assertions.
`ifndef RGB_PIXEL_FORMAT_CONVERTER_MACROS_SVH
`define RGB_PIXEL_FORMAT_CONVERTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rpfc_pkg.sv
// Types and constants of the RGB pixel format converter.
// Depends on nothing; every other file but the macro header imports it.
package rpfc_pkg;

    localparam int unsigned PixelWidth = 32;
    localparam int unsigned HalfWidth  = 16;
    localparam int unsigned FieldWidth = 5;
    localparam int unsigned PackWidth  = 3 * FieldWidth;
    localparam int unsigned MaxChanW   = 16;
    localparam int unsigned CfgIdxW    = 3;

    typedef logic [FieldWidth-1:0] t_field;
    typedef logic [PackWidth-1:0]  t_packed;
    typedef logic [PixelWidth-1:0] t_pixel;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SRC_FOUR_BYTES     = 3'd0,
        CFG_DST_FOUR_BYTES     = 3'd1,
        CFG_SRC_CHANNEL_SHIFTS = 3'd2,
        CFG_SRC_CHANNEL_WIDTHS = 3'd3,
        CFG_DST_CHANNEL_SHIFTS = 3'd4,
        CFG_DST_CHANNEL_WIDTHS = 3'd5
    } t_cfg_idx;

    // Layout of one color channel on both sides.
    typedef struct packed {
        t_field src_shift;
        t_field src_width;
        t_field dst_shift;
        t_field dst_width;
    } t_chan_cfg;

    // Field idx (0 red, 1 green, 2 blue) of a packed 15-bit word.
    function automatic t_field field_of(t_packed packed_word, int unsigned idx);
        return packed_word[idx*FieldWidth +: FieldWidth];
    endfunction

    // Widths hold to 1..16.
    function automatic t_field clamp_width(t_field w);
        t_field res;
        if (w == '0) begin
            res = t_field'(1);
        end else if (w > t_field'(MaxChanW)) begin
            res = t_field'(MaxChanW);
        end else begin
            res = w;
        end
        return res;
    endfunction

endpackage

### src/rpfc_ifs.sv
// Handshake interfaces of the pixel format converter: pixel in, pixel out,
// and the configuration write channel. Depends on rpfc_pkg.
interface rpfc_in_if import rpfc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel src_pixel;
    modport source (output valid, output src_pixel, input ready);
    modport sink   (input valid, input src_pixel, output ready);
endinterface

interface rpfc_out_if import rpfc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel dest_pixel;
    modport source (output valid, output dest_pixel, input ready);
    modport sink   (input valid, input dest_pixel, output ready);
endinterface

interface rpfc_cfg_if import rpfc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    t_packed             data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/rpfc_channel.sv
// One color channel: extract at the source layout, rescale by shifting,
// place at the destination shift. Depends on rpfc_pkg.
module rpfc_channel import rpfc_pkg::*; (
    input  t_pixel    i_pixel,
    input  t_chan_cfg i_cfg,
    output t_pixel    o_placed
);

    t_field                sw;
    t_field                dw;
    t_pixel                shifted;
    logic [MaxChanW-1:0]   mask;
    logic [MaxChanW-1:0]   raw;
    logic [MaxChanW-1:0]   scaled;

    always_comb begin
        sw      = clamp_width(i_cfg.src_width);
        dw      = clamp_width(i_cfg.dst_width);
        shifted = i_pixel >> i_cfg.src_shift;
        mask    = {MaxChanW{1'b1}} >> (t_field'(MaxChanW) - sw);
        raw     = shifted[MaxChanW-1:0] & mask;
        // The value has sw bits, so widening to dw <= 16 never overflows.
        if (dw > sw) begin
            scaled = raw << (dw - sw);
        end else begin
            scaled = raw >> (sw - dw);
        end
        o_placed = {{(PixelWidth-MaxChanW){1'b0}}, scaled} << i_cfg.dst_shift;
    end

endmodule

### src/rgb_pixel_format_converter.sv
// Top level of the RGB pixel format converter.
// Depends on rpfc_pkg, the interfaces in rpfc_ifs.sv, rpfc_channel and the macro header.
//
// Usage: source pixels arrive on i_pix (valid/ready, field src_pixel) and converted
// pixels leave on o_pix (valid/ready, field dest_pixel), one result item per input
// item, in order. The layout registers are written through i_cfg (index 0..5 in
// the order source size, destination size, source shifts, source widths,
// destination shifts, destination widths); i_cfg is always ready, and writes to
// indexes 6 and 7 are ignored. Write configuration only while no item is in flight.
// An accepted item is captured in the input register, which feeds the conversion logic,
// which feeds the result register; o_pix.valid is the valid bit of the result register.
// Throughput is one item per clock while the receiver keeps o_pix.ready high, set by
// the two-register pipeline with no shared unit.
// At reset (i_rst_n low at a clock edge) both pipeline registers empty and all
// layout registers return to zero. When the receiver stalls, the result register
// holds its item and the input register can still take one more item; only when
// both are full does i_pix.ready drop, so ready never depends on input valid.
`include "rgb_pixel_format_converter_macros.svh"

module rgb_pixel_format_converter import rpfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpfc_in_if.sink     i_pix,
    rpfc_out_if.source  o_pix,
    rpfc_cfg_if.sink    i_cfg
);

    // Layout registers.
    logic      r_src_four;
    logic      r_dst_four;
    t_packed   r_src_shifts;
    t_packed   r_src_widths;
    t_packed   r_dst_shifts;
    t_packed   r_dst_widths;

    // Pipeline registers.
    logic      r_in_valid;
    t_pixel    r_in_pixel;
    logic      r_out_valid;
    t_pixel    r_out_pixel;

    logic      s1_ready;
    logic      s2_ready;
    logic      in_accept;
    logic      s1_move;
    t_pixel    src_word;
    t_pixel    placed [3];
    t_pixel    merged;
    t_pixel    n_out_pixel;

    // The configuration port never back-pressures.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_four   <= 1'b0;
            r_dst_four   <= 1'b0;
            r_src_shifts <= '0;
            r_src_widths <= '0;
            r_dst_shifts <= '0;
            r_dst_widths <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SRC_FOUR_BYTES:     r_src_four   <= i_cfg.data[0];
                CFG_DST_FOUR_BYTES:     r_dst_four   <= i_cfg.data[0];
                CFG_SRC_CHANNEL_SHIFTS: r_src_shifts <= i_cfg.data;
                CFG_SRC_CHANNEL_WIDTHS: r_src_widths <= i_cfg.data;
                CFG_DST_CHANNEL_SHIFTS: r_dst_shifts <= i_cfg.data;
                CFG_DST_CHANNEL_WIDTHS: r_dst_widths <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Ready chains backward from the result register to the input register.
    assign s2_ready    = !r_out_valid || o_pix.ready;
    assign s1_ready    = !r_in_valid || s2_ready;
    assign s1_move     = r_in_valid && s2_ready;
    assign i_pix.ready = s1_ready;
    assign in_accept   = i_pix.valid && s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s1_ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_pixel <= i_pix.src_pixel;
        end
    end

    // A two-byte source uses only the low half of the word.
    assign src_word = r_src_four ? r_in_pixel
                                 : {{HalfWidth{1'b0}}, r_in_pixel[HalfWidth-1:0]};

    for (genvar g = 0; g < 3; g++) begin : g_chan
        t_chan_cfg chan_cfg;
        assign chan_cfg = '{
            src_shift: field_of(r_src_shifts, g),
            src_width: field_of(r_src_widths, g),
            dst_shift: field_of(r_dst_shifts, g),
            dst_width: field_of(r_dst_widths, g)
        };
        rpfc_channel u_chan (
            .i_pixel  (src_word),
            .i_cfg    (chan_cfg),
            .o_placed (placed[g])
        );
    end

    // Overlapping channels simply combine by OR.
    assign merged      = placed[0] | placed[1] | placed[2];
    assign n_out_pixel = r_dst_four ? merged
                                    : {{HalfWidth{1'b0}}, merged[HalfWidth-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_pixel <= n_out_pixel;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.dest_pixel = r_out_pixel;

    // An accepted item always lands in the input register.
    `RPFC_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, in_accept, r_in_valid,
        "accepted item did not reach the input register")
    // An item that leaves the input register lands in the result register.
    `RPFC_ASSERT_NEXT(a_s1_move_fills_s2, i_clk, i_rst_n, s1_move, r_out_valid,
        "item lost between input and result register")
    // A blocked input register keeps its item unchanged.
    `RPFC_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_in_valid && !s2_ready,
        r_in_valid && $stable(r_in_pixel), "input register dropped a stalled item")
    // Input ready may only drop when both registers hold items.
    `RPFC_ASSERT_NOW(a_ready_full, i_clk, i_rst_n, !i_pix.ready,
        r_in_valid && r_out_valid, "input stalled with room in the pipeline")

endmodule
